// ----- rtl/cfdl_pkg.sv -----
// shared constants, types and operation codes of the cubic fractional delay line
`default_nettype none

package cfdl_pkg;

  // storage geometry
  localparam int MAX_FRAMES  = 65536;
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;

  // field widths of the ports
  localparam int OP_W    = 2;
  localparam int CH_W    = 3;
  localparam int CFG_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int DELAY_W = 32;
  localparam int COUNT_W = 48;
  localparam int GIDX_W  = COUNT_W + FRAC_W;

  // derived widths
  localparam int POS_W   = $clog2(MAX_FRAMES);
  localparam int LEN_W   = $clog2(MAX_FRAMES + 1);
  localparam int LANE_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CLAMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int C_W     = SAMPLE_BITS + 5;
  localparam int T_W     = SAMPLE_BITS + 8;
  localparam int PROD_W  = T_W + FRAC_W + 1;

  // ring length limits and taps
  localparam int MIN_LEN   = 4;
  localparam int LEN_GUARD = 3;
  localparam int NUM_TAPS  = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE       = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_DELAY  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_GLOBAL = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [NUM_TAPS-1:0] taps_t;

endpackage

`default_nettype wire

// ----- rtl/cubic_fractional_delay_line.sv -----
// top level: circular sample memory, write head, tap fetch and result register
//
//  channel  | ports                                    | transaction
//  ---------+------------------------------------------+-----------------------------
//  input    | in_valid / in_stall, in_* fields         | one write or read request
//  result   | out_valid / out_stall, out_read_value    | one interpolated sample
//  config   | cfg_wr_en, cfg_wr_data                   | ring_length write
//
//  a read passes, from acceptance to the result register, through the delay clamp, position,
//  four tap reads on the single memory port and three horner passes
//  on one multiplier, and is held in the final state while an earlier result is stalled.
//  after reset the memory is cleared one row (all channels) a cycle, with
//  in_stall high; configuration writes are taken during that sweep.
//  writes continue while a result waits in the output register.
`default_nettype none

module cubic_fractional_delay_line (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input transactions
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [cfdl_pkg::OP_W-1:0]           in_operation,
  input  wire logic [cfdl_pkg::CH_W-1:0]           in_channel,
  input  wire logic signed [cfdl_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                                in_frame_end,
  input  wire logic [cfdl_pkg::DELAY_W-1:0]        in_delay_ago,
  input  wire logic [cfdl_pkg::GIDX_W-1:0]         in_global_index,
  // result transactions
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [cfdl_pkg::SAMPLE_BITS-1:0]  out_read_value,
  // configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic [cfdl_pkg::CFG_W-1:0]          cfg_wr_data
);

  localparam int POS_W   = cfdl_pkg::POS_W;
  localparam int LEN_W   = cfdl_pkg::LEN_W;
  localparam int FRAC_W  = cfdl_pkg::FRAC_W;
  localparam int GIDX_W  = cfdl_pkg::GIDX_W;
  localparam int DLY_W   = POS_W + FRAC_W;
  localparam int PW      = LEN_W + FRAC_W + 1;
  localparam int CLAMP_W = cfdl_pkg::CLAMP_W;
  localparam int SB      = cfdl_pkg::SAMPLE_BITS;
  localparam int LANE_W  = cfdl_pkg::LANE_W;

  localparam logic [POS_W-1:0]  CLR_LAST  = POS_W'(cfdl_pkg::MAX_FRAMES - 1);
  localparam logic [2:0]        TAPS_IN   = 3'(cfdl_pkg::NUM_TAPS);
  localparam logic [2:0]        TAPS_DONE = 3'(cfdl_pkg::NUM_TAPS + 1);
  localparam logic [GIDX_W-1:0] DLY_LO    = GIDX_W'(1) << FRAC_W;
  localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_DELAY = 8'b00000100,
    S_POS   = 8'b00001000,
    S_ADDR  = 8'b00010000,
    S_READ  = 8'b00100000,
    S_CALC  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  typedef logic [cfdl_pkg::CHANNELS-1:0][SB-1:0] row_t;

  state_t                        state_r, state_nxt;
  logic [POS_W-1:0]              clr_addr_r;
  logic [LEN_W-1:0]              len_r;
  logic [POS_W-1:0]              wp_r;
  logic [cfdl_pkg::COUNT_W-1:0]  frames_r;
  logic [cfdl_pkg::OP_W-1:0]     op_r;
  logic [cfdl_pkg::CH_W-1:0]     ch_r;
  logic [cfdl_pkg::DELAY_W-1:0]  dly_r;
  logic [GIDX_W-1:0]             gidx_r;
  logic [DLY_W-1:0]              d_r;
  logic [POS_W-1:0]              idx_r;
  logic [FRAC_W-1:0]             frac_r;
  logic [POS_W-1:0]              addr_r;
  logic [2:0]                    rd_cnt_r;
  logic                          rd_vld_r;
  cfdl_pkg::taps_t               tap_r;
  row_t                          rd_row_r;
  logic                          out_valid_r;
  cfdl_pkg::sample_t             out_value_r;

  row_t                          sample_mem [cfdl_pkg::MAX_FRAMES];

  logic                          in_acc, out_free, is_read, ch_ok_in, ch_ok_rd;
  logic                          smp_we, clr_we, issue, hz_start, hz_done;
  logic [POS_W-1:0]              mem_addr;
  logic [LANE_W-1:0]             wr_lane, rd_lane;
  logic [LEN_W-1:0]              wp_inc, addr_inc, len_new;
  logic [CLAMP_W-1:0]            cfg_ext;
  logic [GIDX_W-1:0]             head, d_raw, d_hi;
  logic [GIDX_W:0]               head_diff;
  logic [GIDX_W-1:0]             d_cl;
  logic [PW-1:0]                 p_raw, p_pos;
  cfdl_pkg::sample_t             hz_value;

  // channel range checks
  assign ch_ok_in = ({1'b0, in_channel} < (cfdl_pkg::CH_W + 1)'(cfdl_pkg::CHANNELS));
  assign ch_ok_rd = ({1'b0, ch_r} < (cfdl_pkg::CH_W + 1)'(cfdl_pkg::CHANNELS));
  assign wr_lane  = ch_ok_in ? in_channel[LANE_W-1:0] : '0;
  assign rd_lane  = ch_ok_rd ? ch_r[LANE_W-1:0] : '0;

  // handshakes
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_read  = (in_operation == cfdl_pkg::OP_READ_DELAY) ||
                    (in_operation == cfdl_pkg::OP_READ_GLOBAL);

  // memory port sharing: sweep, tap fetch, otherwise the write head
  assign clr_we = (state_r == S_CLEAR);
  assign smp_we = in_acc && (in_operation == cfdl_pkg::OP_WRITE) && ch_ok_in;
  assign issue  = (state_r == S_READ) && (rd_cnt_r < TAPS_IN);
  always_comb begin
    case (state_r)
      S_CLEAR: mem_addr = clr_addr_r;
      S_READ:  mem_addr = addr_r;
      default: mem_addr = wp_r;
    endcase
  end

  // sample memory, one row holds every channel of a frame
  always_ff @(posedge clk) begin
    if (clr_we) begin
      sample_mem[mem_addr] <= '0;
    end else if (smp_we) begin
      sample_mem[mem_addr][wr_lane] <= in_sample_in;
    end
    rd_row_r <= sample_mem[mem_addr];
  end

  // write head advance and ring length clamp
  assign wp_inc  = LEN_W'(wp_r) + LEN_W'(1);
  assign cfg_ext = CLAMP_W'(cfg_wr_data);
  always_comb begin
    if (cfg_ext < CLAMP_W'(cfdl_pkg::MIN_LEN)) begin
      len_new = LEN_W'(cfdl_pkg::MIN_LEN);
    end else if (cfg_ext > CLAMP_W'(cfdl_pkg::MAX_FRAMES)) begin
      len_new = LEN_W'(cfdl_pkg::MAX_FRAMES);
    end else begin
      len_new = LEN_W'(cfg_ext);
    end
  end

  // delay from either read form, clamped to one frame .. length minus three
  assign head      = {frames_r, FRAC_ZERO};
  assign head_diff = {1'b0, head} - {1'b0, gidx_r};
  assign d_hi      = GIDX_W'({len_r - LEN_W'(cfdl_pkg::LEN_GUARD), FRAC_ZERO});
  always_comb begin
    if (op_r == cfdl_pkg::OP_READ_DELAY) begin
      d_raw = GIDX_W'(dly_r);
    end else if (head_diff[GIDX_W]) begin
      d_raw = '0;
    end else begin
      d_raw = head_diff[GIDX_W-1:0];
    end
    if (d_raw < DLY_LO) begin
      d_cl = DLY_LO;
    end else if (d_raw > d_hi) begin
      d_cl = d_hi;
    end else begin
      d_cl = d_raw;
    end
  end

  // read position behind the write head, wrapped once
  assign p_raw = PW'({wp_r, FRAC_ZERO}) - PW'(d_r);
  assign p_pos = p_raw[PW-1] ? (p_raw + PW'({len_r, FRAC_ZERO})) : p_raw;

  // tap address walks forward modulo the length
  assign addr_inc = LEN_W'(addr_r) + LEN_W'(1);

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc && is_read) state_nxt = S_DELAY;
      S_DELAY: state_nxt = S_POS;
      S_POS:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_READ;
      S_READ:  if (rd_cnt_r == TAPS_DONE) state_nxt = S_CALC;
      S_CALC:  if (hz_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      len_r       <= LEN_W'(cfdl_pkg::MAX_FRAMES);
      wp_r        <= '0;
      frames_r    <= '0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + POS_W'(1);
      end
      // ring length write, or write head advance on a frame end
      if (cfg_wr_en) begin
        len_r <= len_new;
        if (LEN_W'(wp_r) >= len_new) begin
          wp_r <= '0;
        end
      end else if (in_acc && in_operation == cfdl_pkg::OP_WRITE && in_frame_end) begin
        wp_r     <= (wp_inc == len_r) ? '0 : wp_inc[POS_W-1:0];
        frames_r <= frames_r + cfdl_pkg::COUNT_W'(1);
      end
      if (state_r == S_ADDR) begin
        rd_cnt_r <= '0;
      end else if (state_r == S_READ) begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
      end
      // result register
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && is_read) begin
      op_r   <= in_operation;
      ch_r   <= in_channel;
      dly_r  <= in_delay_ago;
      gidx_r <= in_global_index;
    end
    if (state_r == S_DELAY) begin
      d_r <= d_cl[DLY_W-1:0];
    end
    if (state_r == S_POS) begin
      idx_r  <= p_pos[FRAC_W +: POS_W];
      frac_r <= p_pos[FRAC_W-1:0];
    end
    if (state_r == S_ADDR) begin
      addr_r <= (idx_r == '0) ? POS_W'(len_r - LEN_W'(1)) : (idx_r - POS_W'(1));
    end else if (issue) begin
      addr_r <= (addr_inc == len_r) ? '0 : addr_inc[POS_W-1:0];
    end
    // taps shift in oldest first
    if (rd_vld_r) begin
      tap_r[3] <= rd_row_r[rd_lane];
      tap_r[2] <= tap_r[3];
      tap_r[1] <= tap_r[2];
      tap_r[0] <= tap_r[1];
    end
    if (state_r == S_OUT && out_free) begin
      out_value_r <= ch_ok_rd ? hz_value : '0;
    end
  end

  // interpolation
  assign hz_start = (state_r == S_READ) && (rd_cnt_r == TAPS_DONE);

  cfdl_horner u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hz_start),
    .taps  (tap_r),
    .frac  (frac_r),
    .done  (hz_done),
    .value (hz_value)
  );

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;

  // write head stays inside the ring after length changes and advances
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(wp_r) < len_r)
    else $error("write position beyond ring length");

  // ring length stays within its clamp
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r >= LEN_W'(cfdl_pkg::MIN_LEN)) && (len_r <= LEN_W'(cfdl_pkg::MAX_FRAMES)))
    else $error("ring length outside clamp");

  // tap fetch addresses stay inside the ring
  a_addr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (LEN_W'(addr_r) < len_r))
    else $error("tap address beyond ring length");

  // interpolator finishes only while the sequencer waits for it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    hz_done |-> (state_r == S_CALC))
    else $error("interpolator done outside wait state");

  // a new result appears only from the output state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result register loaded outside output state");

endmodule

`default_nettype wire

// ----- rtl/cfdl_horner.sv -----
// catmull-rom coefficients and horner evaluation on one shared multiplier
`default_nettype none

module cfdl_horner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire cfdl_pkg::taps_t                   taps,
  input  wire logic [cfdl_pkg::FRAC_W-1:0]       frac,
  output logic                                   done,
  output cfdl_pkg::sample_t                      value
);

  localparam int C_W    = cfdl_pkg::C_W;
  localparam int T_W    = cfdl_pkg::T_W;
  localparam int PROD_W = cfdl_pkg::PROD_W;
  localparam int FRAC_W = cfdl_pkg::FRAC_W;
  localparam int SB     = cfdl_pkg::SAMPLE_BITS;

  localparam logic signed [PROD_W-1:0] HALF =
    {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [T_W-1:0] SAT_HI = {{(T_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [T_W-1:0] SAT_LO = {{(T_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic [1:0] LAST_PASS = 2'd2;

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_ACC  = 4'b0100,
    H_FIN  = 4'b1000
  } hphase_t;

  hphase_t                  phase_r, phase_nxt;
  logic [1:0]               pass_r;
  logic signed [C_W-1:0]    c0_r, c1_r, c2_r, y1x2_r;
  logic [FRAC_W-1:0]        frac_r;
  logic signed [T_W-1:0]    t_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     done_r;
  cfdl_pkg::sample_t        value_r;

  logic signed [C_W-1:0]    e0, e1, e2, e3, d12;
  logic signed [T_W-1:0]    mul_a, addend, rnd_t, t_nxt, half_t;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [PROD_W-1:0] prod, rnd;

  // sign-extended taps and the doubled coefficients
  assign e0  = C_W'(taps[0]);
  assign e1  = C_W'(taps[1]);
  assign e2  = C_W'(taps[2]);
  assign e3  = C_W'(taps[3]);
  assign d12 = e1 - e2;

  // shared multiplier: c0 on the first pass, the running sum after that
  assign mul_a  = (pass_r == 2'd0) ? T_W'(c0_r) : t_r;
  assign frac_s = $signed({1'b0, frac_r});
  assign prod   = mul_a * frac_s;

  // round to nearest by adding half and flooring, then add this pass's term
  assign rnd = (prod_r + HALF) >>> FRAC_W;
  assign rnd_t = rnd[T_W-1:0];
  always_comb begin
    case (pass_r)
      2'd0:    addend = T_W'(c1_r);
      2'd1:    addend = T_W'(c2_r);
      default: addend = T_W'(y1x2_r);
    endcase
  end
  assign t_nxt = rnd_t + addend;

  // final halving with rounding
  assign half_t = (t_r + T_W'(1)) >>> 1;

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      H_IDLE: if (start) phase_nxt = H_MUL;
      H_MUL:  phase_nxt = H_ACC;
      H_ACC:  phase_nxt = (pass_r == LAST_PASS) ? H_FIN : H_MUL;
      H_FIN:  phase_nxt = H_IDLE;
      default: phase_nxt = H_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= H_IDLE;
      pass_r  <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == H_FIN);
      if (phase_r == H_IDLE) begin
        pass_r <= 2'd0;
      end else if (phase_r == H_ACC) begin
        pass_r <= pass_r + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (phase_r == H_IDLE && start) begin
      c0_r   <= (e3 - e0) + d12 + (d12 <<< 1);
      c1_r   <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c2_r   <= e2 - e0;
      y1x2_r <= e1 <<< 1;
      frac_r <= frac;
    end
    if (phase_r == H_MUL) begin
      prod_r <= prod;
    end
    if (phase_r == H_ACC) begin
      t_r <= t_nxt;
    end
    if (phase_r == H_FIN) begin
      if (half_t > SAT_HI) begin
        value_r <= SAT_HI[SB-1:0];
      end else if (half_t < SAT_LO) begin
        value_r <= SAT_LO[SB-1:0];
      end else begin
        value_r <= half_t[SB-1:0];
      end
    end
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

`default_nettype wire

// ----- tb/cubic_fractional_delay_line_checker.sv -----
// checker: watches both channels and the config port, predicts each read and compares
module cubic_fractional_delay_line_checker
  import cfdl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic [OP_W-1:0]        in_operation,
  input  wire logic [CH_W-1:0]        in_channel,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  wire logic                   in_frame_end,
  input  wire logic [DELAY_W-1:0]     in_delay_ago,
  input  wire logic [GIDX_W-1:0]      in_global_index,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] out_read_value,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  output int                          failures,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the block's state
  sample_t            lane_mem [CHANNELS][MAX_FRAMES];
  int                 ring_len;
  int                 head_pos;
  logic [COUNT_W-1:0] frames_done;
  sample_t            expected_reads [$];

  // frame index folded into the ring
  function automatic int ring_wrap(longint x);
    longint m;
    m = x % ring_len;
    if (m < 0) m += ring_len;
    return int'(m);
  endfunction

  // add half an lsb, then floor by 2^s
  function automatic longint rounded_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // catmull-rom read at a q.16 distance behind the write head
  function automatic sample_t interpolate_at(logic [CH_W-1:0] ch, logic [GIDX_W-1:0] dly);
    logic [GIDX_W-1:0] d;
    logic [GIDX_W-1:0] d_max;
    longint p, i, f, c0, c1, c2, t, v, s_max;
    longint y [NUM_TAPS];
    if (ch >= CHANNELS) return '0;
    d = dly;
    d_max = 64'(ring_len - LEN_GUARD) << FRAC_W;
    if (d < 64'(1) << FRAC_W) d = 64'(1) << FRAC_W;
    if (d > d_max) d = d_max;
    p = longint'(head_pos) * 65536 - longint'(d);
    if (p < 0) p += longint'(ring_len) * 65536;
    i = p >>> FRAC_W;
    f = p & 64'hFFFF;
    for (int k = 0; k < NUM_TAPS; k++) y[k] = longint'(lane_mem[ch][ring_wrap(i - 1 + k)]);
    c0 = -y[0] + 3 * y[1] - 3 * y[2] + y[3];
    c1 = 2 * y[0] - 5 * y[1] + 4 * y[2] - y[3];
    c2 = y[2] - y[0];
    t = rounded_shift(c0 * f, FRAC_W) + c1;
    t = rounded_shift(t * f, FRAC_W) + c2;
    t = rounded_shift(t * f, FRAC_W) + 2 * y[1];
    v = rounded_shift(t, 1);
    s_max = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    if (v > s_max) v = s_max;
    else if (v < -s_max - 1) v = -s_max - 1;
    return sample_t'(v);
  endfunction

  // one pass per clock edge: config, result compare, then the accepted request
  always @(posedge clk) begin : watch
    sample_t            want;
    int                 len_req;
    logic [GIDX_W-1:0]  head;
    logic [GIDX_W-1:0]  gap;
    if (!rst_n) begin
      foreach (lane_mem[c, k]) lane_mem[c][k] = '0;
      ring_len = MAX_FRAMES;
      head_pos = 0;
      frames_done = '0;
      expected_reads.delete();
      failures = 0;
    end else begin
      // ring length write, clamped, head pulled back inside the ring
      if (cfg_wr_en) begin
        len_req = int'(cfg_wr_data);
        if (len_req < MIN_LEN) len_req = MIN_LEN;
        if (len_req > MAX_FRAMES) len_req = MAX_FRAMES;
        ring_len = len_req;
        if (head_pos >= ring_len) head_pos = 0;
      end

      // result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: read_value %0d arrived with no read outstanding",
                   $time, out_read_value);
          failures++;
        end else begin
          want = expected_reads.pop_front();
          if (out_read_value !== want) begin
            $display("%0t: read_value expected %0d, actual %0d", $time, want, out_read_value);
            failures++;
          end
        end
      end

      // input transaction
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_WRITE: begin
            if (in_channel < CHANNELS) lane_mem[in_channel][head_pos] = in_sample_in;
            if (in_frame_end) begin
              head_pos = (head_pos + 1) % ring_len;
              frames_done = frames_done + 1'b1;
            end
          end
          OP_READ_DELAY: begin
            expected_reads.push_back(interpolate_at(in_channel, 64'(in_delay_ago)));
          end
          OP_READ_GLOBAL: begin
            head = {frames_done, {FRAC_W{1'b0}}};
            gap = (in_global_index >= head) ? '0 : head - in_global_index;
            expected_reads.push_back(interpolate_at(in_channel, gap));
          end
          default: ;
        endcase
      end
      pending = expected_reads.size();
    end
  end

endmodule

// ----- tb/cubic_fractional_delay_line_test.sv -----
// testbench top: clock, reset, request and config stimulus, output stall and verdict
module cubic_fractional_delay_line_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cfdl_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int STALL_LIMIT   = 300_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 170;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_operation = OP_WRITE;
  logic [CH_W-1:0]           in_channel = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                      in_frame_end = 1'b0;
  logic [DELAY_W-1:0]        in_delay_ago = '0;
  logic [GIDX_W-1:0]         in_global_index = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_read_value;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]          cfg_wr_data = '0;

  int                        failures;
  int                        pending;
  int                        quiet_cycles = 0;
  logic                      steady = 1'b0;
  logic [COUNT_W-1:0]        frame_count = '0;
  int                        len_now = MAX_FRAMES;
  int                        lengths [6] = '{3, 131071, 5, 37, 1000, 65535};

  cubic_fractional_delay_line dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_sample_in    (in_sample_in),
    .in_frame_end    (in_frame_end),
    .in_delay_ago    (in_delay_ago),
    .in_global_index (in_global_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  cubic_fractional_delay_line_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_sample_in    (in_sample_in),
    .in_frame_end    (in_frame_end),
    .in_delay_ago    (in_delay_ago),
    .in_global_index (in_global_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .failures        (failures),
    .pending         (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure, off during the steady phase
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 10);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("cubic_fractional_delay_line_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request transaction, with random gaps ahead of it
  task automatic put(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                     input sample_t smp, input logic fe,
                     input logic [DELAY_W-1:0] dly, input logic [GIDX_W-1:0] gidx);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_channel      <= ch;
    in_sample_in    <= smp;
    in_frame_end    <= fe;
    in_delay_ago    <= dly;
    in_global_index <= gidx;
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE && fe) frame_count++;
    @(negedge clk);
  endtask

  // drain outstanding reads, then give a trailing write time to land
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ring length write once outstanding reads have drained
  task automatic set_length(input int v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    len_now = (v < MIN_LEN) ? MIN_LEN : (v > MAX_FRAMES) ? MAX_FRAMES : v;
  endtask

  // full-scale samples with the rails now and then
  function automatic sample_t draw_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 24'h7FFFFF;
    if (r < 10) return 24'h800000;
    return sample_t'($urandom);
  endfunction

  // a delay within the recently written frames
  function automatic logic [DELAY_W-1:0] near_delay();
    int span;
    span = (len_now < 200) ? len_now : 200;
    return {16'($urandom_range(0, span)), 16'($urandom)};
  endfunction

  function automatic logic [DELAY_W-1:0] draw_delay();
    int r;
    logic [DELAY_W-1:0] top_edge;
    r = $urandom_range(0, 99);
    top_edge = 32'(len_now - LEN_GUARD) << FRAC_W;
    if (r < 70) return near_delay();
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 32'h0001_0000;
      2:       return top_edge;
      default: return top_edge + 1;
    endcase
  endfunction

  function automatic logic [GIDX_W-1:0] draw_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {frame_count, 16'h0} - 64'(near_delay());
    if (r < 85) return {$urandom, $urandom};
    if (r < 92) return '1;
    return 64'($urandom_range(0, 1 << 20));
  endfunction

  // mostly whole frames across both channels, with reads and some noise between
  task automatic random_phase(input int n);
    int made;
    int pick;
    logic [CH_W-1:0] ch;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(2, 7)) : CH_W'($urandom_range(0, 1));
      if (pick < 40) begin
        put(OP_WRITE, 3'd0, draw_sample(), 1'b0, $urandom, {$urandom, $urandom});
        put(OP_WRITE, 3'd1, draw_sample(), 1'b1, $urandom, {$urandom, $urandom});
        made += 2;
      end else begin
        if (pick < 50)
          put(OP_WRITE, ch, draw_sample(), 1'($urandom), $urandom, {$urandom, $urandom});
        else if (pick < 75)
          put(OP_READ_DELAY, ch, draw_sample(), 1'($urandom), draw_delay(),
              {$urandom, $urandom});
        else if (pick < 95)
          put(OP_READ_GLOBAL, ch, draw_sample(), 1'($urandom), $urandom, draw_position());
        else
          put(OP_NONE, ch, draw_sample(), 1'($urandom), $urandom, {$urandom, $urandom});
        made++;
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: short ring, rails, clamps, wrap, dead channels, unused operation
    set_length(8);
    put(OP_WRITE, 3'd0, 24'h7FFFFF, 1'b0, '0, '0);
    put(OP_WRITE, 3'd1, 24'h800000, 1'b1, '0, '0);
    put(OP_WRITE, 3'd0, 24'h800000, 1'b0, '0, '0);
    put(OP_WRITE, 3'd1, 24'h7FFFFF, 1'b1, '0, '0);
    put(OP_WRITE, 3'd0, 24'h7FFFFF, 1'b1, '1, '1);
    put(OP_WRITE, 3'd0, 24'h800000, 1'b1, '0, '0);
    put(OP_WRITE, 3'd7, 24'h123456, 1'b1, '0, '0);
    put(OP_READ_DELAY, 3'd0, '0, 1'b0, 32'h0000_0000, '0);
    put(OP_READ_DELAY, 3'd0, '1, 1'b1, 32'hFFFF_FFFF, '0);
    put(OP_READ_DELAY, 3'd0, '0, 1'b0, 32'h0002_8000, '0);
    put(OP_READ_DELAY, 3'd1, '0, 1'b0, 32'h0001_8000, '0);
    put(OP_READ_DELAY, 3'd6, '0, 1'b0, 32'h0002_4000, '0);
    put(OP_READ_GLOBAL, 3'd0, '0, 1'b0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    put(OP_READ_GLOBAL, 3'd1, '0, 1'b0, '0, 64'h0);
    put(OP_READ_GLOBAL, 3'd0, '0, 1'b0, '0, {frame_count, 16'h0} - 64'h3_0001);
    put(OP_NONE, 3'd0, '1, 1'b1, '1, '1);
    put(OP_WRITE, 3'd0, 24'h000001, 1'b1, '0, '0);
    put(OP_WRITE, 3'd1, 24'hFFFFFF, 1'b1, '0, '0);
    put(OP_WRITE, 3'd0, 24'h000000, 1'b1, '0, '0);
    put(OP_READ_DELAY, 3'd0, '0, 1'b0, 32'h0001_0000, '0);
    put(OP_READ_DELAY, 3'd1, '0, 1'b0, 32'h0004_C000, '0);
    put(OP_READ_GLOBAL, 3'd0, '0, 1'b0, '0, {frame_count, 16'h0} - 64'h8000);

    // random phases over a spread of ring lengths, one without any idling
    foreach (lengths[p]) begin
      set_length(lengths[p]);
      steady = (p == 3);
      random_phase(PHASE_ITEMS);
    end
    steady = 1'b0;
    settle();

    if (failures == 0) begin
      $display("cubic_fractional_delay_line_test passed");
    end else begin
      $display("cubic_fractional_delay_line_test failed");
    end
    $finish;
  end

endmodule
